[hdl/cpra_pkg.sv]
// Shared types, codes and constants for the contiguous page run allocator.
`default_nettype none
package cpra_pkg;

    localparam int OP_W    = 2;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PAGE_W  = 17;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [1:0] ent_t;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    localparam logic [CFG_W-1:0] TOTAL_RESET    = 11'd1024;
    localparam logic [CFG_W-1:0] RESERVED_RESET = 11'd0;

    localparam ent_t ENT_FREE  = 2'b00;
    localparam ent_t ENT_MID   = 2'b01;
    localparam ent_t ENT_LAST  = 2'b10;
    localparam ent_t ENT_FIRST = 2'b11;

    typedef enum logic [1:0] {
        WU_INIT,
        WU_SCAN,
        WU_MARK,
        WU_FREE
    } wu_mode_t;

    typedef struct packed {
        wu_mode_t mode;
        page_t    base;
        page_t    size;
        page_t    count;
        page_t    run_in;
        page_t    lo;
        page_t    hi;
    } wu_ctl_t;

    typedef struct packed {
        logic  hit;
        logic  stop;
        page_t end_page;
        page_t run_out;
        page_t cleared;
    } wu_stat_t;

endpackage
`default_nettype wire

[hdl/cpra_if.sv]
// Handshake channel interfaces: request, result and register write.
`default_nettype none
interface cpra_in_if;
    logic                         valid;
    logic                         ready;
    logic [cpra_pkg::OP_W-1:0]    operation;
    logic [cpra_pkg::COUNT_W-1:0] page_count;
    logic [cpra_pkg::INDEX_W-1:0] page_index;

    modport source (output valid, output operation, output page_count,
                    output page_index, input ready);
    modport sink (input valid, input operation, input page_count,
                  input page_index, output ready);
endinterface

interface cpra_out_if;
    logic                         valid;
    logic                         ready;
    logic [cpra_pkg::STAT_W-1:0]  status;
    logic [cpra_pkg::INDEX_W-1:0] first_page;
    logic [cpra_pkg::COUNT_W-1:0] pages_freed;

    modport source (output valid, output status, output first_page,
                    output pages_freed, input ready);
    modport sink (input valid, input status, input first_page,
                  input pages_freed, output ready);
endinterface

interface cpra_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cpra_pkg::CFG_IDX_W-1:0] index;
    logic [cpra_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/cpra_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cpra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hdl/cpra_word_unit.sv]
// Shared word unit: evaluates or rewrites one map word of PPW pages.
`default_nettype none
module cpra_word_unit #(
    parameter int PPW = 16
) (
    input  wire cpra_pkg::wu_ctl_t ctl,
    input  wire logic [2*PPW-1:0]  rdata,
    output logic      [2*PPW-1:0]  wdata,
    output cpra_pkg::wu_stat_t     stat
);

    cpra_pkg::page_t pg  [PPW];
    cpra_pkg::page_t run [PPW];
    cpra_pkg::ent_t  code [PPW];
    logic [PPW-1:0] inmap;
    logic [PPW-1:0] is_free;
    logic [PPW-1:0] hit;
    logic [PPW-1:0] islast;
    logic [PPW-1:0] clr;

    always_comb
    begin : lane_eval
        logic            seen;
        cpra_pkg::page_t last_nf;
        logic            blocked;
        for (int j = 0; j < PPW; j++)
        begin
            pg[j]      = ctl.base + cpra_pkg::page_t'(j);
            code[j]    = rdata[2*j +: 2];
            inmap[j]   = pg[j] < ctl.size;
            is_free[j] = inmap[j] && (code[j] == cpra_pkg::ENT_FREE);
            islast[j]  = inmap[j] && (pg[j] >= ctl.lo) && (code[j] == cpra_pkg::ENT_LAST);
        end
        for (int j = 0; j < PPW; j++)
        begin
            seen    = 1'b0;
            last_nf = '0;
            blocked = 1'b0;
            for (int k = 0; k < PPW; k++)
            begin
                if (k <= j && !is_free[k])
                begin
                    seen    = 1'b1;
                    last_nf = cpra_pkg::page_t'(k);
                end
                if (k < j && islast[k])
                begin
                    blocked = 1'b1;
                end
            end
            if (!is_free[j])
            begin
                run[j] = '0;
            end
            else if (seen)
            begin
                run[j] = cpra_pkg::page_t'(j) - last_nf;
            end
            else
            begin
                run[j] = ctl.run_in + cpra_pkg::page_t'(j + 1);
            end
            hit[j] = is_free[j] && (run[j] >= ctl.count);
            clr[j] = inmap[j] && (pg[j] >= ctl.lo) && !blocked;
        end
    end

    always_comb
    begin
        stat.hit      = |hit;
        stat.stop     = |islast;
        stat.run_out  = run[PPW-1];
        stat.cleared  = cpra_pkg::page_t'($countones(clr));
        stat.end_page = '0;
        for (int j = PPW - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                stat.end_page = pg[j];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < PPW; j++)
        begin
            case (ctl.mode)
                cpra_pkg::WU_INIT:
                begin
                    wdata[2*j +: 2] = (pg[j] < ctl.lo) ? cpra_pkg::ENT_LAST
                                                       : cpra_pkg::ENT_FREE;
                end
                cpra_pkg::WU_MARK:
                begin
                    if (pg[j] >= ctl.lo && pg[j] <= ctl.hi)
                    begin
                        if (pg[j] == ctl.hi)
                        begin
                            wdata[2*j +: 2] = cpra_pkg::ENT_LAST;
                        end
                        else if (pg[j] == ctl.lo)
                        begin
                            wdata[2*j +: 2] = cpra_pkg::ENT_FIRST;
                        end
                        else
                        begin
                            wdata[2*j +: 2] = cpra_pkg::ENT_MID;
                        end
                    end
                    else
                    begin
                        wdata[2*j +: 2] = code[j];
                    end
                end
                cpra_pkg::WU_FREE:
                begin
                    wdata[2*j +: 2] = clr[j] ? cpra_pkg::ENT_FREE : code[j];
                end
                default:
                begin
                    wdata[2*j +: 2] = code[j];
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/contiguous_page_run_allocator_top.sv]
// Top level: sequencer over the page map RAM and the shared word unit.
// After reset a clearing pass writes all WORDS map words, ready low.
// Allocate: reads and evaluates each word up to the run's last page, then reads and rewrites each word marked.
// Free: reads and rewrites each word from word 0 through the word holding the end marker or the map's end.
// Initialize: writes all WORDS map words; every item then passes through S_DONE to the output register.
// One item at a time through the RAM port and word unit.
`default_nettype none
module contiguous_page_run_allocator_top #(
    parameter int PAGES          = 1024,
    parameter int PAGES_PER_WORD = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpra_in_if.sink    in_ch,
    cpra_out_if.source out_ch,
    cpra_cfg_if.sink   cfg
);

    localparam int WORDS = (PAGES + PAGES_PER_WORD - 1) / PAGES_PER_WORD;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WW    = 2 * PAGES_PER_WORD;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(WORDS - 1);
    localparam cpra_pkg::page_t PAGES_P   = cpra_pkg::page_t'(PAGES);
    localparam cpra_pkg::page_t STEP_P    = cpra_pkg::page_t'(PAGES_PER_WORD);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_INIT  = 10'b0000000100,
        S_ARD   = 10'b0000001000,
        S_AEVAL = 10'b0000010000,
        S_MRD   = 10'b0000100000,
        S_MWR   = 10'b0001000000,
        S_FRD   = 10'b0010000000,
        S_FWR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [cpra_pkg::OP_W-1:0]    op_reg, op_next;
    cpra_pkg::page_t              count_reg, count_next;
    cpra_pkg::page_t              index_reg, index_next;
    logic [AW-1:0]                addr_reg, addr_next;
    cpra_pkg::page_t              base_reg, base_next;
    cpra_pkg::page_t              run_reg, run_next;
    cpra_pkg::page_t              lo_reg, lo_next;
    cpra_pkg::page_t              hi_reg, hi_next;
    cpra_pkg::page_t              freed_reg, freed_next;
    logic [cpra_pkg::STAT_W-1:0]  res_status_reg, res_status_next;
    logic [cpra_pkg::INDEX_W-1:0] res_first_reg, res_first_next;
    logic                         active_reg, active_next;
    logic [cpra_pkg::CFG_W-1:0]   total_reg, total_next;
    logic [cpra_pkg::CFG_W-1:0]   reserved_reg, reserved_next;
    logic                         out_valid_reg, out_valid_next;
    logic [cpra_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [cpra_pkg::INDEX_W-1:0] out_first_reg, out_first_next;
    logic [cpra_pkg::COUNT_W-1:0] out_freed_reg, out_freed_next;

    cpra_pkg::page_t    size;
    cpra_pkg::page_t    base_plus;
    logic               at_end;
    logic               in_take;
    logic               out_load;
    logic               ram_we;
    logic [WW-1:0]      ram_rdata;
    logic [WW-1:0]      ram_wdata;
    cpra_pkg::wu_ctl_t  wu_ctl;
    cpra_pkg::wu_stat_t wu_stat;

    assign size = (cpra_pkg::page_t'(total_reg) < PAGES_P) ? cpra_pkg::page_t'(total_reg)
                                                          : PAGES_P;
    assign base_plus = base_reg + STEP_P;
    assign at_end    = (base_plus >= size) || (addr_reg == LAST_ADDR);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.first_page  = out_first_reg;
    assign out_ch.pages_freed = out_freed_reg;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    assign ram_we = (state_reg == S_CLEAR) || (state_reg == S_INIT)
                 || (state_reg == S_MWR) || (state_reg == S_FWR);

    always_comb
    begin
        wu_ctl.base   = base_reg;
        wu_ctl.size   = size;
        wu_ctl.count  = count_reg;
        wu_ctl.run_in = run_reg;
        wu_ctl.lo     = lo_reg;
        wu_ctl.hi     = hi_reg;
        case (state_reg)
            S_CLEAR, S_INIT: wu_ctl.mode = cpra_pkg::WU_INIT;
            S_MWR:           wu_ctl.mode = cpra_pkg::WU_MARK;
            S_FWR:
            begin
                wu_ctl.mode = cpra_pkg::WU_FREE;
                wu_ctl.lo   = index_reg;
            end
            default:         wu_ctl.mode = cpra_pkg::WU_SCAN;
        endcase
    end

    cpra_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    cpra_word_unit #(
        .PPW (PAGES_PER_WORD)
    ) u_word (
        .ctl   (wu_ctl),
        .rdata (ram_rdata),
        .wdata (ram_wdata),
        .stat  (wu_stat)
    );

    always_comb
    begin
        total_next    = total_reg;
        reserved_next = reserved_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                cpra_pkg::CFG_TOTAL:    total_next    = cfg.data;
                cpra_pkg::CFG_RESERVED: reserved_next = cfg.data;
                default:                total_next    = total_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        index_next      = index_reg;
        addr_next       = addr_reg;
        base_next       = base_reg;
        run_next        = run_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_freed_next  = out_freed_reg;

        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_first_next  = res_first_reg;
            out_freed_next  = freed_reg[cpra_pkg::COUNT_W-1:0];
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR, S_INIT:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    if (state_reg == S_INIT)
                    begin
                        active_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                    base_next = base_plus;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next         = in_ch.operation;
                    count_next      = cpra_pkg::page_t'(in_ch.page_count);
                    index_next      = cpra_pkg::page_t'(in_ch.page_index);
                    addr_next       = '0;
                    base_next       = '0;
                    run_next        = '0;
                    freed_next      = '0;
                    res_status_next = cpra_pkg::ST_OK;
                    res_first_next  = '0;
                    case (in_ch.operation)
                        cpra_pkg::OP_INIT:
                        begin
                            lo_next    = cpra_pkg::page_t'(reserved_reg);
                            state_next = S_INIT;
                        end
                        cpra_pkg::OP_ALLOC:
                        begin
                            if (!active_reg)
                            begin
                                res_status_next = cpra_pkg::ST_INACTIVE;
                                state_next      = S_DONE;
                            end
                            else if (in_ch.page_count == '0)
                            begin
                                res_status_next = cpra_pkg::ST_NOFIT;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ARD;
                            end
                        end
                        cpra_pkg::OP_FREE:
                        begin
                            if (!active_reg)
                            begin
                                res_status_next = cpra_pkg::ST_INACTIVE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ARD:
            begin
                state_next = S_AEVAL;
            end
            S_AEVAL:
            begin
                if (wu_stat.hit)
                begin
                    hi_next    = wu_stat.end_page;
                    lo_next    = wu_stat.end_page + cpra_pkg::page_t'(1) - count_reg;
                    state_next = S_MRD;
                end
                else if (at_end)
                begin
                    res_status_next = cpra_pkg::ST_NOFIT;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next  = addr_reg + AW'(1);
                    base_next  = base_plus;
                    run_next   = wu_stat.run_out;
                    state_next = S_ARD;
                end
            end
            S_MRD:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                if (base_reg <= lo_reg)
                begin
                    res_first_next = lo_reg[cpra_pkg::INDEX_W-1:0];
                    state_next     = S_DONE;
                end
                else
                begin
                    addr_next  = addr_reg - AW'(1);
                    base_next  = base_reg - STEP_P;
                    state_next = S_MRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FWR;
            end
            S_FWR:
            begin
                freed_next = freed_reg + wu_stat.cleared;
                if (wu_stat.stop || at_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next  = addr_reg + AW'(1);
                    base_next  = base_plus;
                    state_next = S_FRD;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            base_reg      <= '0;
            lo_reg        <= '0;
            active_reg    <= 1'b0;
            total_reg     <= cpra_pkg::TOTAL_RESET;
            reserved_reg  <= cpra_pkg::RESERVED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            base_reg      <= base_next;
            lo_reg        <= lo_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            reserved_reg  <= reserved_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        count_reg      <= count_next;
        index_reg      <= index_next;
        run_reg        <= run_next;
        hi_reg         <= hi_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_freed_reg  <= out_freed_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass re-entered after reset");

    a_mark_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MWR) |-> (lo_reg <= hi_reg))
        else $error("run start beyond run end while marking");

    a_mark_active: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MRD) || (state_reg == S_FRD)) |-> active_reg)
        else $error("map touched before initialize");

    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg == cpra_pkg::OP_FREE) |-> (freed_reg <= size))
        else $error("freed count exceeds map size");

endmodule
`default_nettype wire

[bench/contiguous_page_run_allocator_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for contiguous_page_run_allocator_top: page map tracker plus drivers.

localparam int MAP_PAGES = 1024;

typedef logic [cpra_pkg::OP_W-1:0]      op_t;
typedef logic [cpra_pkg::STAT_W-1:0]    status_t;
typedef logic [cpra_pkg::INDEX_W-1:0]   index_t;
typedef logic [cpra_pkg::COUNT_W-1:0]   count_t;
typedef logic [cpra_pkg::CFG_IDX_W-1:0] reg_idx_t;
typedef logic [cpra_pkg::CFG_W-1:0]     reg_data_t;

typedef struct packed {
    status_t status;
    index_t  first_page;
    count_t  pages_freed;
} page_result_t;

class page_map_tracker;
    cpra_pkg::ent_t pages [MAP_PAGES];
    bit             active;
    int             total_pages;
    int             reserved_pages;
    page_result_t   pending [$];
    int             run_starts [$];
    int             errors;

    function new();
        foreach (pages[p])
            pages[p] = cpra_pkg::ENT_FREE;
        active = 1'b0;
        total_pages = int'(cpra_pkg::TOTAL_RESET);
        reserved_pages = int'(cpra_pkg::RESERVED_RESET);
        errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, reg_data_t value);
        if (idx == cpra_pkg::CFG_TOTAL)
            total_pages = int'(value);
        else
            reserved_pages = int'(value);
    endfunction

    function void note_request(op_t op, count_t count, index_t index);
        page_result_t r;
        int size, lim, run, start, cleared, p, k;
        cpra_pkg::ent_t old;
        r = '0;
        size = (total_pages < MAP_PAGES) ? total_pages : MAP_PAGES;
        if (op == cpra_pkg::OP_INIT)
        begin
            lim = (reserved_pages < MAP_PAGES) ? reserved_pages : MAP_PAGES;
            foreach (pages[q])
                pages[q] = (q < lim) ? cpra_pkg::ENT_LAST : cpra_pkg::ENT_FREE;
            active = 1'b1;
            run_starts.delete();
        end
        else if (op == cpra_pkg::OP_ALLOC)
        begin
            if (!active)
                r.status = cpra_pkg::ST_INACTIVE;
            else
            begin
                r.status = cpra_pkg::ST_NOFIT;
                run = 0;
                if (count != '0)
                begin
                    for (p = 0; p < size; p++)
                    begin
                        if (pages[p] != cpra_pkg::ENT_FREE)
                            run = 0;
                        else
                        begin
                            run++;
                            if (run == int'(count))
                            begin
                                start = p + 1 - int'(count);
                                for (k = start; k <= p; k++)
                                    pages[k] = (k == p) ? cpra_pkg::ENT_LAST :
                                               (k == start) ? cpra_pkg::ENT_FIRST
                                                            : cpra_pkg::ENT_MID;
                                r.status = cpra_pkg::ST_OK;
                                r.first_page = index_t'(start);
                                run_starts.push_back(start);
                                break;
                            end
                        end
                    end
                end
            end
        end
        else if (op == cpra_pkg::OP_FREE)
        begin
            if (!active)
                r.status = cpra_pkg::ST_INACTIVE;
            else
            begin
                cleared = 0;
                for (p = int'(index); p < size; p++)
                begin
                    old = pages[p];
                    pages[p] = cpra_pkg::ENT_FREE;
                    cleared++;
                    if (old == cpra_pkg::ENT_LAST)
                        break;
                end
                r.pages_freed = count_t'(cleared);
            end
        end
        pending.push_back(r);
    endfunction

    function void report(string what, int want, int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(page_result_t got);
        page_result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected, expected nothing, actual %0d/%0d/%0d",
                     $time, got.status, got.first_page, got.pages_freed);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            report("status", int'(want.status), int'(got.status));
        if (got.first_page !== want.first_page)
            report("first_page", int'(want.first_page), int'(got.first_page));
        if (got.pages_freed !== want.pages_freed)
            report("pages_freed", int'(want.pages_freed), int'(got.pages_freed));
    endfunction
endclass

module contiguous_page_run_allocator_top_test;
    localparam op_t OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES = 8;

    logic clk = 1'b0;
    logic rst_n;

    cpra_in_if  in_if ();
    cpra_out_if out_if ();
    cpra_cfg_if cfg_if ();

    contiguous_page_run_allocator_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    page_map_tracker tracker = new();
    int calm_sends;
    int calm_takes;
    int results_taken;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input op_t op, input count_t count, input index_t index);
        int gap;
        if (calm_sends > 0)
        begin
            gap = 0;
            calm_sends--;
        end
        else
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 49) == 0)
                calm_sends = 40;
        end
        if (gap > 0)
        begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.operation  = op;
        in_if.page_count = count;
        in_if.page_index = index;
        in_if.valid      = 1'b1;
        do @(posedge clk); while (!in_if.ready);
        tracker.note_request(op, count, index);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        wait_idle();
        cfg_if.index = idx;
        cfg_if.data  = reg_data_t'(value);
        cfg_if.valid = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        tracker.set_reg(idx, reg_data_t'(value));
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic count_t rand_count(input int lo, input int hi);
        return count_t'($urandom_range(lo, hi));
    endfunction

    function automatic index_t rand_index();
        return index_t'($urandom_range(0, 1023));
    endfunction

    function automatic count_t draw_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return rand_count(1, 8);
        if (roll < 85)
            return rand_count(9, 64);
        if (roll < 95)
            return rand_count(65, 400);
        if (roll < 97)
            return '0;
        return rand_count(401, 1024);
    endfunction

    // mostly allocate / free of live runs, some stray frees, re-inits and unused codes
    task automatic run_phase(input int n);
        int roll, pick, start;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_request(cpra_pkg::OP_INIT, rand_count(0, 1024), rand_index());
            else if (roll < 3)
                send_request(OP_UNUSED, rand_count(0, 1024), rand_index());
            else if (roll < 10)
                send_request(cpra_pkg::OP_FREE, rand_count(0, 1024), rand_index());
            else if (roll < 55 && tracker.run_starts.size() != 0)
            begin
                pick = $urandom_range(0, tracker.run_starts.size() - 1);
                start = tracker.run_starts[pick];
                tracker.run_starts.delete(pick);
                send_request(cpra_pkg::OP_FREE, rand_count(0, 1024), index_t'(start));
            end
            else
                send_request(cpra_pkg::OP_ALLOC, draw_count(), rand_index());
        end
    endtask

    initial
    begin
        int gap;
        page_result_t got;
        out_if.ready = 1'b0;
        calm_takes = 0;
        results_taken = 0;
        @(negedge clk);
        forever
        begin
            if (results_taken == 150 || results_taken == 1000)
                gap = 400;
            else if (calm_takes > 0)
            begin
                gap = 0;
                calm_takes--;
            end
            else
            begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 49) == 0)
                    calm_takes = 40;
            end
            if (gap > 0)
            begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_if.ready = 1'b1;
            do @(posedge clk); while (!out_if.valid);
            got.status      = out_if.status;
            got.first_page  = out_if.first_page;
            got.pages_freed = out_if.pages_freed;
            tracker.check_result(got);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int ph, tot, res;
        in_if.valid      = 1'b0;
        in_if.operation  = cpra_pkg::OP_ALLOC;
        in_if.page_count = '0;
        in_if.page_index = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = cpra_pkg::CFG_TOTAL;
        cfg_if.data      = '0;
        calm_sends       = 0;
        rst_n            = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // not initialized yet
        send_request(cpra_pkg::OP_ALLOC, 5, 0);
        send_request(cpra_pkg::OP_FREE, 0, 0);
        send_request(OP_UNUSED, 0, 0);
        send_request(cpra_pkg::OP_INIT, 0, 0);
        send_request(cpra_pkg::OP_ALLOC, 0, 0);
        send_request(cpra_pkg::OP_ALLOC, 1024, 0);
        send_request(cpra_pkg::OP_ALLOC, 1, 0);
        send_request(cpra_pkg::OP_FREE, 0, 0);
        send_request(cpra_pkg::OP_ALLOC, 1, 0);
        send_request(cpra_pkg::OP_ALLOC, 3, 0);
        send_request(cpra_pkg::OP_ALLOC, 2, 0);
        send_request(cpra_pkg::OP_FREE, 0, 1);
        send_request(cpra_pkg::OP_FREE, 0, 1023);
        // no end marker before the top of the map
        send_request(cpra_pkg::OP_FREE, 0, 1020);
        send_request(OP_UNUSED, 1024, 1023);
        send_request(cpra_pkg::OP_ALLOC, 1024, 0);
        // reserved beyond a small map
        write_reg(cpra_pkg::CFG_TOTAL, 10);
        write_reg(cpra_pkg::CFG_RESERVED, 1024);
        send_request(cpra_pkg::OP_INIT, 0, 0);
        send_request(cpra_pkg::OP_ALLOC, 1, 0);
        send_request(cpra_pkg::OP_FREE, 0, 5);
        send_request(cpra_pkg::OP_FREE, 0, 1000);
        send_request(cpra_pkg::OP_ALLOC, 1, 0);
        send_request(cpra_pkg::OP_ALLOC, 11, 0);
        // registers changed after init
        write_reg(cpra_pkg::CFG_TOTAL, 1024);
        write_reg(cpra_pkg::CFG_RESERVED, 3);
        send_request(cpra_pkg::OP_ALLOC, 4, 0);
        send_request(cpra_pkg::OP_FREE, 0, 0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    tot = 1024;
                    res = 0;
                end
                1:
                begin
                    tot = 1;
                    res = 0;
                end
                2:
                begin
                    tot = 1024;
                    res = 512;
                end
                3:
                begin
                    tot = 64;
                    res = 70;
                end
                4:
                begin
                    tot = $urandom_range(1, 1024);
                    res = $urandom_range(0, tot);
                end
                5:
                begin
                    tot = 1000;
                    res = 17;
                end
                6:
                begin
                    tot = $urandom_range(1, 1024);
                    res = $urandom_range(0, 1024);
                end
                default:
                begin
                    tot = 1024;
                    res = 1;
                end
            endcase
            write_reg(cpra_pkg::CFG_TOTAL, tot);
            write_reg(cpra_pkg::CFG_RESERVED, res);
            if (ph != PHASES - 1)
                send_request(cpra_pkg::OP_INIT, rand_count(0, 1024), rand_index());
            run_phase(RANDOM_ITEMS / PHASES);
        end

        in_if.valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
